// ----- rtl/mqps_pkg.sv -----
package mqps_pkg;

   localparam int NUM_QUEUES_DEF  = 8;
   localparam int STORE_DEPTH_DEF = 64;
   localparam int MAX_RESULTS     = 64;
   localparam int QW   = 3;
   localparam int CW   = 7;
   localparam int IDW  = 31;
   localparam int PRW  = 31;
   localparam int FIFO_DEPTH = 2;

   typedef enum logic [1:0] {
      ACT_ASSIGN  = 2'd0,
      ACT_EXECUTE = 2'd1,
      ACT_MERGE   = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_ASSIGNED = 3'd0,
      KIND_EXECUTED = 3'd1,
      KIND_MERGED   = 3'd2,
      KIND_REFUSED  = 3'd3,
      KIND_FULL     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0]     action;
      logic [QW-1:0]  queue;
      logic [QW-1:0]  other_queue;
      logic [IDW-1:0] task_id;
      logic [PRW-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [2:0]     kind;
      logic [QW-1:0]  queue_out;
      logic [CW-1:0]  count;
      logic [IDW-1:0] task_out;
      logic [PRW-1:0] priority_out;
      logic           last;
   } rsp_type;

endpackage

// ----- rtl/mqps_ram.sv -----
module mqps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/mqps_front.sv -----
module mqps_front #(
   parameter int NUM_QUEUES = mqps_pkg::NUM_QUEUES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mqps_pkg::req_type req_word,
   output logic              fifo_valid,
   output mqps_pkg::req_type fifo_word,
   input  logic              fifo_pop
);

   localparam int PW = $clog2(mqps_pkg::FIFO_DEPTH);

   mqps_pkg::req_type    buf_ff [mqps_pkg::FIFO_DEPTH];
   logic [PW-1:0]        wptr_ff, rptr_ff;
   logic [PW:0]          fill_ff;
   logic                 keep;
   logic                 push;

   // drop words that cannot give results or change state
   always_comb begin
      keep = (32'(req_word.queue) < NUM_QUEUES);
      if (req_word.action == mqps_pkg::ACT_NONE) begin
         keep = 1'b0;
      end
      if (req_word.action == mqps_pkg::ACT_MERGE &&
          32'(req_word.other_queue) >= NUM_QUEUES) begin
         keep = 1'b0;
      end
   end

   assign busy       = (fill_ff == (PW+1)'(mqps_pkg::FIFO_DEPTH));
   assign push       = start && !busy && keep;
   assign fifo_valid = (fill_ff != '0);
   assign fifo_word  = buf_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (fifo_pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + (PW+1)'(push) - (PW+1)'(fifo_pop);
      end
      if (push) begin
         buf_ff[wptr_ff] <= req_word;
      end
   end

endmodule

// ----- rtl/mqps_back.sv -----
module mqps_back #(
   parameter int NUM_QUEUES  = mqps_pkg::NUM_QUEUES_DEF,
   parameter int STORE_DEPTH = mqps_pkg::STORE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [mqps_pkg::CW-1:0]   threshold,
   input  logic                      fifo_valid,
   input  mqps_pkg::req_type         fifo_word,
   output logic                      fifo_pop,
   output logic                      rsp_valid,
   output mqps_pkg::rsp_type         rsp_word,
   output logic                      flush
);

   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int QIW = $clog2(NUM_QUEUES);
   localparam int NCW = $clog2(STORE_DEPTH + 1);
   localparam int TW  = mqps_pkg::IDW + mqps_pkg::PRW;
   localparam int EW  = mqps_pkg::QW + TW;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_SCAN, S_SCAN_TAIL, S_RESULT
   } state_type;

   state_type             state_ff;
   mqps_pkg::req_type     cur_ff;
   logic [STORE_DEPTH-1:0] valid_ff;
   logic [NCW-1:0]        count_ff [NUM_QUEUES];
   logic [AW-1:0]         idx_ff;
   logic [AW-1:0]         rd_slot_ff;
   logic                  rd_live_ff;
   logic                  best_hit_ff;
   logic [AW-1:0]         best_slot_ff;
   logic [mqps_pkg::PRW-1:0] best_pr_ff;
   logic [mqps_pkg::IDW-1:0] best_id_ff;
   logic [mqps_pkg::PRW-1:0] first_pr_ff;
   logic [mqps_pkg::CW-1:0]  npop_ff;
   logic                  rsp_valid_ff;
   logic                  flush_ff;
   mqps_pkg::rsp_type     rsp_ff;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data, rd_data;
   logic [mqps_pkg::QW-1:0]  rd_owner;
   logic [mqps_pkg::IDW-1:0] rd_id;
   logic [mqps_pkg::PRW-1:0] rd_pr;
   logic                  from_oq;
   logic                  hit;
   logic                  relabel;
   logic                  better;
   logic [AW-1:0]         free_slot;
   logic                  free_hit;
   logic [QIW-1:0]        qi, oqi;

   // store entry: owner, task id, priority
   mqps_ram #(.WIDTH(EW), .DEPTH(STORE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign qi       = QIW'(cur_ff.queue);
   assign oqi      = QIW'(cur_ff.other_queue);
   assign rd_owner = rd_data[EW-1:TW];
   assign rd_id    = rd_data[TW-1:mqps_pkg::PRW];
   assign rd_pr    = rd_data[mqps_pkg::PRW-1:0];
   // a merge relabels source entries as the search passes them
   assign from_oq  = rd_live_ff && (cur_ff.action == mqps_pkg::ACT_MERGE) &&
                     (rd_owner == cur_ff.other_queue);
   assign hit      = (rd_live_ff && rd_owner == cur_ff.queue) || from_oq;
   assign relabel  = from_oq && (cur_ff.other_queue != cur_ff.queue) &&
                     (state_ff == S_SCAN || state_ff == S_SCAN_TAIL);
   assign better   = !best_hit_ff || rd_pr > best_pr_ff ||
                     (rd_pr == best_pr_ff && rd_id < best_id_ff);
   assign wr_en    = relabel || ((state_ff == S_FIND) && free_hit &&
                                 (cur_ff.action == mqps_pkg::ACT_ASSIGN));
   assign wr_addr  = relabel ? rd_slot_ff : free_slot;
   assign wr_data  = {cur_ff.queue, relabel ? rd_data[TW-1:0]
                                            : {cur_ff.task_id, cur_ff.priority_req}};
   assign fifo_pop  = (state_ff == S_IDLE) && fifo_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign flush     = flush_ff;

   always_comb begin
      free_hit  = 1'b0;
      free_slot = '0;
      for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_hit  = 1'b1;
            free_slot = AW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      flush_ff     <= 1'b0;
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         rd_live_ff <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            count_ff[q] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (fifo_valid) begin
                  cur_ff   <= fifo_word;
                  npop_ff  <= '0;
                  state_ff <= S_FIND;
               end
            end
            S_FIND: begin
               rsp_ff.queue_out    <= cur_ff.queue;
               rsp_ff.count        <= '0;
               rsp_ff.task_out     <= '0;
               rsp_ff.priority_out <= '0;
               rsp_ff.last         <= 1'b1;
               idx_ff       <= '0;
               rd_live_ff   <= 1'b0;
               best_hit_ff  <= 1'b0;
               case (cur_ff.action)
                  mqps_pkg::ACT_ASSIGN: begin
                     if (free_hit) begin
                        valid_ff[free_slot] <= 1'b1;
                        count_ff[qi]        <= count_ff[qi] + 1'b1;
                        rsp_ff.kind  <= mqps_pkg::KIND_ASSIGNED;
                        rsp_ff.count <= mqps_pkg::CW'(count_ff[qi] + 1'b1);
                     end else begin
                        rsp_ff.kind  <= mqps_pkg::KIND_FULL;
                        rsp_ff.count <= mqps_pkg::CW'(count_ff[qi]);
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  mqps_pkg::ACT_MERGE: begin
                     if (32'(count_ff[oqi]) < 32'(threshold)) begin
                        rsp_ff.kind  <= mqps_pkg::KIND_REFUSED;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        if (oqi != qi) begin
                           count_ff[qi]  <= count_ff[qi] + count_ff[oqi];
                           count_ff[oqi] <= '0;
                        end
                        state_ff <= S_SCAN;
                     end
                  end
                  default: begin
                     state_ff <= S_SCAN;
                  end
               endcase
            end
            S_SCAN, S_SCAN_TAIL: begin
               // read pipeline: address idx_ff, data next cycle
               rd_slot_ff <= idx_ff;
               rd_live_ff <= (state_ff == S_SCAN) && valid_ff[idx_ff];
               if (hit && better) begin
                  best_hit_ff  <= 1'b1;
                  best_slot_ff <= rd_slot_ff;
                  best_pr_ff   <= rd_pr;
                  best_id_ff   <= rd_id;
               end
               if (state_ff == S_SCAN) begin
                  if (idx_ff == AW'(STORE_DEPTH - 1)) begin
                     state_ff <= S_SCAN_TAIL;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  state_ff <= S_RESULT;
               end
            end
            S_RESULT: begin
               idx_ff      <= '0;
               rd_live_ff  <= 1'b0;
               best_hit_ff <= 1'b0;
               if (cur_ff.action == mqps_pkg::ACT_MERGE) begin
                  rsp_ff.kind         <= best_hit_ff ? mqps_pkg::KIND_MERGED
                                                     : mqps_pkg::KIND_FULL;
                  rsp_ff.priority_out <= best_hit_ff ? best_pr_ff : '0;
                  rsp_ff.last         <= 1'b1;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end else if (best_hit_ff &&
                            (npop_ff == '0 || best_pr_ff == first_pr_ff)) begin
                  valid_ff[best_slot_ff] <= 1'b0;
                  if (count_ff[qi] != '0) begin
                     count_ff[qi] <= count_ff[qi] - 1'b1;
                  end
                  if (npop_ff == '0) begin
                     first_pr_ff <= best_pr_ff;
                  end
                  npop_ff         <= npop_ff + 1'b1;
                  rsp_ff.kind     <= mqps_pkg::KIND_EXECUTED;
                  rsp_ff.task_out <= best_id_ff;
                  rsp_ff.last     <= (32'(npop_ff) == mqps_pkg::MAX_RESULTS - 1);
                  rsp_valid_ff    <= 1'b1;
                  state_ff <= (32'(npop_ff) == mqps_pkg::MAX_RESULTS - 1) ? S_IDLE
                                                                         : S_SCAN;
               end else begin
                  // stop: the held pop, if any, is the last
                  flush_ff <= (npop_ff != '0);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/mqps_out.sv -----
module mqps_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  mqps_pkg::rsp_type in_word,
   input  logic              flush,
   output logic              rsp_strobe,
   output mqps_pkg::rsp_type rsp_word
);

   // one-deep hold so the last flag can be set on a pending executed word
   logic              hold_ff;
   mqps_pkg::rsp_type word_ff;
   logic              strobe_ff;
   mqps_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (in_valid) begin
            if (hold_ff) begin
               strobe_ff <= 1'b1;
               out_ff    <= word_ff;
            end
            if (in_word.last) begin
               if (!hold_ff) begin
                  strobe_ff <= 1'b1;
                  out_ff    <= in_word;
               end else begin
                  word_ff <= in_word;
               end
               hold_ff <= hold_ff;
            end else begin
               word_ff <= in_word;
               hold_ff <= 1'b1;
            end
         end else if (flush && hold_ff) begin
            strobe_ff    <= 1'b1;
            out_ff       <= word_ff;
            out_ff.last  <= 1'b1;
            hold_ff      <= 1'b0;
         end else if (hold_ff && word_ff.last) begin
            strobe_ff <= 1'b1;
            out_ff    <= word_ff;
            hold_ff   <= 1'b0;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = out_ff;

endmodule

// ----- rtl/multi_queue_priority_scheduler.sv -----
// Assign and refused merge answer from S_FIND; an allowed merge answers after a search of
// the whole store, one store read per cycle. An executed word waits for the next search to
// set its last flag. Throughput: one word in the back end at a time; an execute with k pops
// takes k + 1 searches (k at the result cap). A two-word queue takes words meanwhile.
// Synchronous reset empties the store, counts and threshold; the receiver cannot stall.
module multi_queue_priority_scheduler #(
   parameter int NUM_QUEUES  = mqps_pkg::NUM_QUEUES_DEF,
   parameter int STORE_DEPTH = mqps_pkg::STORE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  mqps_pkg::req_type       req_word,
   input  logic                    csr_wr_en,
   input  logic [mqps_pkg::CW-1:0] csr_wr_data,
   output logic                    rsp_strobe,
   output mqps_pkg::rsp_type       rsp_word
);

   logic [mqps_pkg::CW-1:0] threshold_ff;
   logic                    fifo_valid, fifo_pop, b_valid, b_flush;
   mqps_pkg::req_type       fifo_word;
   mqps_pkg::rsp_type       b_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   mqps_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .fifo_valid(fifo_valid), .fifo_word(fifo_word),
      .fifo_pop(fifo_pop)
   );

   mqps_back #(.NUM_QUEUES(NUM_QUEUES), .STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock(clock), .reset(reset), .threshold(threshold_ff),
      .fifo_valid(fifo_valid), .fifo_word(fifo_word), .fifo_pop(fifo_pop),
      .rsp_valid(b_valid), .rsp_word(b_word), .flush(b_flush)
   );

   // back end emits executed words unflagged but at the result cap; a stop with pops pending flushes
   mqps_out u_out (
      .clock(clock), .reset(reset), .in_valid(b_valid), .in_word(b_word),
      .flush(b_flush), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

endmodule
